// ===== hdl/lpr_pkg.sv =====
// Shared types and constants of the length-prefixed packet receiver.
package lpr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_DATA_DEF = 64;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;
    localparam logic [LEN_W-1:0]     MAX_LEN_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b1;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] rx_byte;
    } t_rx_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  packet_length;
        logic              is_last;
    } t_pkt_word;

    typedef struct packed {
        logic start;
        logic tick;
        logic store;
        logic rd;
    } t_cmd;

    typedef struct packed {
        logic len_ok;
        logic last_byte;
        logic tick_timeout;
        logic timeout;
        logic is_last;
    } t_status;

endpackage

// ===== hdl/lpr_stream_if.sv =====
// Valid/ready channel that carries one word of a given payload type.
interface lpr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/length_prefixed_packet_receiver.sv =====
// Length-prefixed packet receiver with packet timeout: top level.
//
// Each input word is a received byte or a one-millisecond tick. While idle or
// receiving, one input word is taken every cycle. Once the last payload byte of
// a packet arrives, input stalls while the packet drains from the packet store:
// first a registered read is started, then one result word is given per cycle
// while the output is ready.
module length_prefixed_packet_receiver #(
    parameter int unsigned MAX_DATA = lpr_pkg::MAX_DATA_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lpr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lpr_stream_if.sink                      i_rx,
    lpr_stream_if.source                    o_pkt
);
    import lpr_pkg::*;

    t_cmd      cmd;
    t_status   status;
    t_rx_word  rx_word;
    t_pkt_word pkt_word;
    logic      rx_ready;
    logic      out_valid;

    assign rx_word = i_rx.data;

    lpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx.valid),
        .i_rx_func   (rx_word.func),
        .o_rx_ready  (rx_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_pkt.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lpr_datapath #(
        .MAX_DATA (int'(MAX_DATA))
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_word  (rx_word),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_pkt_word (pkt_word)
    );

    assign i_rx.ready  = rx_ready;
    assign o_pkt.valid = out_valid;
    assign o_pkt.data  = pkt_word;
endmodule

// ===== hdl/lpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/lpr_datapath.sv =====
// Datapath: configuration, length, count and timer registers and the packet store.
module lpr_datapath #(
    parameter int MAX_DATA = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lpr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  lpr_pkg::t_rx_word                   i_rx_word,
    input  lpr_pkg::t_cmd                       i_cmd,
    output lpr_pkg::t_status                    o_status,
    output lpr_pkg::t_pkt_word                  o_pkt_word
);
    import lpr_pkg::*;

    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    typedef logic [AW-1:0] t_addr;

    logic [TIMEOUT_W-1:0] r_timeout;
    logic [LEN_W-1:0]     r_max_len;
    logic [LEN_W-1:0]     r_exp_len;
    logic [LEN_W-1:0]     r_count;
    logic [LEN_W-1:0]     r_rd_idx;
    logic [TIMEOUT_W-1:0] r_elapsed;
    logic                 r_is_last;
    logic [TIMEOUT_W-1:0] n_elapsed;
    logic [BYTE_W-1:0]    rd_data;

    assign n_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_max_len <= MAX_LEN_RESET;
            r_exp_len <= '0;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_elapsed <= '0;
            r_is_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_MAX_LEN: r_max_len <= i_cfg_data[LEN_W-1:0];
                endcase
            end
            if (i_cmd.start) begin
                r_exp_len <= i_rx_word.rx_byte[LEN_W-1:0];
                r_count   <= '0;
                r_rd_idx  <= '0;
                r_elapsed <= '0;
            end
            if (i_cmd.tick) begin
                r_elapsed <= n_elapsed;
            end
            if (i_cmd.store) begin
                r_count <= r_count + 7'd1;
            end
            if (i_cmd.rd) begin
                r_rd_idx  <= r_rd_idx + 7'd1;
                r_is_last <= ({1'b0, r_rd_idx} + 8'd1) == {1'b0, r_exp_len};
            end
        end
    end

    lpr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_DATA),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (t_addr'(r_count)),
        .i_wdata (i_rx_word.rx_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (t_addr'(r_rd_idx)),
        .o_rdata (rd_data)
    );

    always_comb begin
        o_status.len_ok = (i_rx_word.rx_byte != 8'd0)
                       && (i_rx_word.rx_byte <= {1'b0, r_max_len})
                       && ({1'b0, i_rx_word.rx_byte} <= 9'(MAX_DATA));
        o_status.last_byte    = ({1'b0, r_count} + 8'd1) >= {1'b0, r_exp_len};
        o_status.tick_timeout = n_elapsed > r_timeout;
        o_status.timeout      = r_elapsed > r_timeout;
        o_status.is_last      = r_is_last;
    end

    assign o_pkt_word.out_byte      = rd_data;
    assign o_pkt_word.packet_length = r_exp_len;
    assign o_pkt_word.is_last       = r_is_last;
endmodule

// ===== hdl/lpr_ctrl.sv =====
// Controller: state machine for idle, receive and drain phases.
module lpr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    input  logic               i_rx_func,
    output logic               o_rx_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lpr_pkg::t_status   i_status,
    output lpr_pkg::t_cmd      o_cmd
);
    import lpr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RECV,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   rx_acc;

    assign o_rx_ready  = (r_state != S_DRAIN);
    assign o_out_valid = r_out_valid;
    assign rx_acc      = i_rx_valid && o_rx_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (rx_acc) begin
                    if (i_rx_func == FUNC_TICK) begin
                        o_cmd.tick = 1'b1;
                    end else if (i_status.len_ok) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RECV;
                    end
                end
            end
            S_RECV: begin
                if (rx_acc) begin
                    if (i_rx_func == FUNC_TICK) begin
                        o_cmd.tick = 1'b1;
                        if (i_status.tick_timeout) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.store = 1'b1;
                        if (i_status.last_byte) begin
                            n_state     = S_DRAIN;
                            n_out_valid = 1'b0;
                        end else if (i_status.timeout) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (!r_out_valid) begin
                    o_cmd.rd    = 1'b1;
                    n_out_valid = 1'b1;
                end else if (i_out_ready) begin
                    if (i_status.is_last) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b0;
                    end else begin
                        o_cmd.rd = 1'b1;
                    end
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_valid_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_DRAIN))
        else $error("Output word is valid outside the drain phase.");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && i_status.is_last) |=> (r_state == S_IDLE))
        else $error("Drain did not end after the last word was taken.");

    a_start_enters_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_RECV))
        else $error("Packet start did not enter the receive phase.");
endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the length-prefixed packet receiver with a packet scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_SLACK = 8;

    class pkt_scoreboard;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [LEN_W-1:0]     max_len;
        bit                   busy;
        logic [LEN_W-1:0]     exp_len;
        logic [LEN_W-1:0]     rcvd;
        logic [TIMEOUT_W-1:0] elapsed;
        logic [BYTE_W-1:0]    payload [MAX_DATA_DEF];
        t_pkt_word            pending_q [$];
        int                   errors;
        int                   n_done;
        int                   n_dropped;
        int                   n_checked;

        function new();
            timeout_ms = TIMEOUT_RESET;
            max_len    = MAX_LEN_RESET;
            busy       = 1'b0;
            exp_len    = '0;
            rcvd       = '0;
            elapsed    = '0;
            errors     = 0;
            n_done     = 0;
            n_dropped  = 0;
            n_checked  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TIMEOUT: timeout_ms = val[TIMEOUT_W-1:0];
                CFG_MAX_LEN: max_len = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_word(t_rx_word w);
            t_pkt_word r;
            if (w.func == FUNC_TICK) begin
                if (elapsed != 16'hFFFF) elapsed++;
            end else if (!busy) begin
                if (w.rx_byte >= 1 && w.rx_byte <= max_len && w.rx_byte <= MAX_DATA_DEF) begin
                    exp_len = w.rx_byte[LEN_W-1:0];
                    rcvd    = '0;
                    elapsed = '0;
                    busy    = 1'b1;
                end
            end else begin
                payload[rcvd] = w.rx_byte;
                rcvd++;
                if (rcvd >= exp_len) begin
                    for (int i = 0; i < int'(exp_len); i++) begin
                        r.out_byte      = payload[i];
                        r.packet_length = exp_len;
                        r.is_last       = (i + 1 == int'(exp_len));
                        pending_q.push_back(r);
                    end
                    busy = 1'b0;
                    rcvd = '0;
                    n_done++;
                    return;
                end
            end
            if (busy && elapsed > timeout_ms) begin
                busy = 1'b0;
                rcvd = '0;
                n_dropped++;
            end
        endfunction

        function void check_word(t_pkt_word got);
            t_pkt_word want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result byte=%h len=%0d last=%b",
                         $time, got.out_byte, got.packet_length, got.is_last);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (got.out_byte !== want.out_byte) begin
                $display("%0t: out_byte expected %h, got %h", $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.packet_length !== want.packet_length) begin
                $display("%0t: packet_length expected %0d, got %0d",
                         $time, want.packet_length, got.packet_length);
                errors++;
            end
            if (got.is_last !== want.is_last) begin
                $display("%0t: is_last expected %b, got %b", $time, want.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit send_idle;
    bit recv_idle;
    int items_sent;
    int n_settings;

    pkt_scoreboard sb = new();

    lpr_stream_if #(.T(t_rx_word))  rx_if ();
    lpr_stream_if #(.T(t_pkt_word)) pkt_if ();

    length_prefixed_packet_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_if),
        .o_pkt      (pkt_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int draw_gap(bit idle_on);
        return idle_on ? int'($urandom_range(0, 11)) : 0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) sb.note_word(rx_if.data);
            if (pkt_if.valid && pkt_if.ready) sb.check_word(pkt_if.data);
        end
    end

    initial begin
        int gap;
        pkt_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = draw_gap(recv_idle);
            if (gap > 0) begin
                pkt_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pkt_if.ready = 1'b1;
            do @(posedge i_clk); while (!pkt_if.valid);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((rx_if.valid && rx_if.ready) || (pkt_if.valid && pkt_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_word(logic func, logic [BYTE_W-1:0] b);
        t_rx_word w;
        int gap;
        w.func    = func;
        w.rx_byte = b;
        gap = draw_gap(send_idle);
        if (gap > 0) begin
            rx_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid = 1'b1;
        rx_if.data  = w;
        do @(posedge i_clk); while (!rx_if.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        rx_if.valid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    // Any open packet is completed with filler bytes so that registers change only while idle.
    task automatic configure(logic [TIMEOUT_W-1:0] t, logic [LEN_W-1:0] m);
        while (sb.busy) push_word(FUNC_BYTE, BYTE_W'($urandom_range(0, 255)));
        wait_drained();
        cfg_we   = 1'b1;
        cfg_idx  = CFG_TIMEOUT;
        cfg_data = t;
        @(negedge i_clk);
        cfg_idx  = CFG_MAX_LEN;
        cfg_data = {{(CFG_DATA_W-LEN_W){1'b0}}, m};
        @(negedge i_clk);
        cfg_we   = 1'b0;
        sb.set_reg(CFG_TIMEOUT, t);
        sb.set_reg(CFG_MAX_LEN, {{(CFG_DATA_W-LEN_W){1'b0}}, m});
        n_settings++;
    endtask

    task automatic send_packet(int len, int tick_pct);
        push_word(FUNC_BYTE, BYTE_W'(len));
        for (int i = 0; i < len; i++) begin
            while (int'($urandom_range(0, 99)) < tick_pct)
                push_word(FUNC_TICK, BYTE_W'($urandom));
            push_word(FUNC_BYTE, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(int n_items, logic [TIMEOUT_W-1:0] t, logic [LEN_W-1:0] m,
                             bit s_idle, bit r_idle);
        int start;
        int roll;
        int len;
        int pct;
        configure(t, m);
        send_idle = s_idle;
        recv_idle = r_idle;
        pct   = (t <= 8) ? 20 : 5;
        start = items_sent;
        while (items_sent - start < n_items) begin
            roll = $urandom_range(0, 9);
            if (roll < 7) begin
                if ($urandom_range(0, 7) == 0) len = m;
                else len = $urandom_range(1, (m < 8) ? m : 8);
                send_packet(len, pct);
            end else if (roll == 7) begin
                repeat ($urandom_range(1, 3)) push_word(FUNC_BYTE, BYTE_W'($urandom_range(0, 255)));
            end else if (roll == 8) begin
                repeat ($urandom_range(1, 4)) push_word(FUNC_TICK, BYTE_W'($urandom));
            end else begin
                len = $urandom_range(1, m);
                push_word(FUNC_BYTE, BYTE_W'(len));
                repeat ($urandom_range(0, len - 1))
                    push_word(FUNC_BYTE, BYTE_W'($urandom_range(0, 255)));
                if (t <= 20) repeat (int'(t) + 1) push_word(FUNC_TICK, BYTE_W'($urandom));
            end
        end
        wait_drained();
    endtask

    initial begin
        rx_if.valid = 1'b0;
        rx_if.data  = '0;
        cfg_we      = 1'b0;
        cfg_idx     = CFG_TIMEOUT;
        cfg_data    = '0;
        i_rst_n     = 1'b0;
        send_idle   = 1'b0;
        recv_idle   = 1'b1;
        items_sent  = 0;
        n_settings  = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        push_word(FUNC_TICK, 8'hFF);
        push_word(FUNC_BYTE, 8'h00);
        push_word(FUNC_BYTE, 8'd65);
        push_word(FUNC_BYTE, 8'hFF);
        push_word(FUNC_BYTE, 8'd1);
        push_word(FUNC_BYTE, 8'hFF);
        push_word(FUNC_BYTE, 8'd2);
        push_word(FUNC_BYTE, 8'h00);
        push_word(FUNC_BYTE, 8'hAA);

        configure(16'd1, 7'd64);
        send_idle = 1'b1;
        push_word(FUNC_BYTE, 8'd3);
        push_word(FUNC_BYTE, 8'h55);
        push_word(FUNC_TICK, 8'h00);
        push_word(FUNC_TICK, 8'h00);
        push_word(FUNC_BYTE, 8'h80);
        push_word(FUNC_BYTE, 8'd2);
        push_word(FUNC_TICK, 8'h00);
        push_word(FUNC_BYTE, 8'h01);
        push_word(FUNC_BYTE, 8'hFE);

        configure(16'd200, 7'd5);
        push_word(FUNC_BYTE, 8'd6);
        send_packet(5, 0);

        // With the longest timeout a packet outlives a long run of ticks.
        configure(16'hFFFF, 7'd64);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        push_word(FUNC_BYTE, 8'd2);
        push_word(FUNC_BYTE, 8'h3C);
        repeat (40) push_word(FUNC_TICK, BYTE_W'($urandom));
        push_word(FUNC_BYTE, 8'hC3);
        wait_drained();

        run_phase(40, 16'd200, 7'd64, 1'b1, 1'b1);
        run_phase(40, 16'd1, 7'd1, 1'b0, 1'b0);
        run_phase(40, 16'hFFFF, 7'd64, 1'b1, 1'b0);
        send_packet(64, 0);
        run_phase(40, TIMEOUT_W'($urandom_range(1, 20)), LEN_W'($urandom_range(1, 64)),
                  1'b0, 1'b1);
        run_phase(40, 16'd3, 7'd8, 1'b1, 1'b1);
        run_phase(40, TIMEOUT_W'($urandom_range(1, 65535)), 7'd64, 1'b1, 1'b1);
        run_phase(40, 16'd2, LEN_W'($urandom_range(1, 64)), 1'b1, 1'b1);

        wait_drained();
        repeat (20) @(negedge i_clk);

        if (sb.pending_q.size() != 0) begin
            $display("%0t: %0d expected result words never arrived",
                     $time, sb.pending_q.size());
            sb.errors++;
        end
        $display("Sent %0d input words under %0d register settings.", items_sent, n_settings);
        $display("Checked %0d result words from %0d packets; %0d partial packets timed out.",
                 sb.n_checked, sb.n_done, sb.n_dropped);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lpr_pkg.sv
hdl/lpr_stream_if.sv
hdl/lpr_ram.sv
hdl/lpr_datapath.sv
hdl/lpr_ctrl.sv
hdl/length_prefixed_packet_receiver.sv
bench/tb.sv
